>>> rtl/core/lge_pkg.sv
// Shared types and constants for the life generation engine.
// Used by lge_control, lge_datapath and life_generation_engine_top; no dependencies.
package lge_pkg;

   // Field widths fixed by the item format.
   localparam int OP_W    = 2;
   localparam int COORD_W = 6;
   localparam int CFG_W   = 7;
   localparam int CSR_IDX_W = 1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   // Reset value of both grid dimensions.
   localparam logic [CFG_W-1:0] GRID_DIM_RESET = 7'd64;

   // Commands from the controller to the datapath, registered in the controller.
   typedef struct packed {
      logic clear;        // write zeros to row row_index of bank 0
      logic cell_read;    // read the captured row of the active bank
      logic cell_update;  // write back the modified row on an in-range write and load the result
      logic sweep;        // read row row_index of the active bank for a generation
   } lge_cmd_type;

endpackage

>>> rtl/core/lge_control.sv
// Controller state machine of the life generation engine.
// Depends on lge_pkg; drives command strobes and the row counter of lge_datapath.
module lge_control
   import lge_pkg::*;
#(
   parameter int MAX_HEIGHT = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [OP_W-1:0]                       req_operation,
   output logic                                  busy,
   output logic                                  capture,
   output lge_cmd_type                           cmd,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]       row_index
);

   localparam int CNT_W = $clog2(MAX_HEIGHT + 1);
   localparam logic [CNT_W-1:0] LAST_ROW  = CNT_W'(MAX_HEIGHT - 1);
   localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(MAX_HEIGHT);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CELL_RD,
      S_CELL_WB,
      S_SWEEP,
      S_DRAIN
   } state_type;

   state_type         state_ff;
   logic              busy_ff;
   lge_cmd_type       cmd_ff;
   lge_cmd_type       cmd_in;
   logic [CNT_W-1:0]  cnt_ff;

   // A transfer happens whenever start meets an idle engine.
   assign capture   = start && !busy_ff;
   assign busy      = busy_ff;
   assign cmd       = cmd_ff;
   assign row_index = cnt_ff;

   // Command strobes for the next cycle; reset starts the clearing pass at row 0.
   always_comb begin
      cmd_in = '0;
      if (reset) begin
         cmd_in.clear = 1'b1;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               cmd_in.clear = (cnt_ff != LAST_ROW);
            end
            S_IDLE: begin
               if (start) begin
                  if (req_operation == OP_STEP) begin
                     cmd_in.sweep = 1'b1;
                  end else begin
                     cmd_in.cell_read = 1'b1;
                  end
               end
            end
            S_CELL_RD: begin
               cmd_in.cell_update = 1'b1;
            end
            S_SWEEP: begin
               // One extra count past the last row flushes the row window.
               cmd_in.sweep = (cnt_ff != SWEEP_END);
            end
            default: ;
         endcase
      end
   end

   // State, row counter and registered commands.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (cnt_ff == LAST_ROW) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (start) begin
                  busy_ff <= 1'b1;
                  if (req_operation == OP_STEP) begin
                     state_ff <= S_SWEEP;
                     cnt_ff   <= '0;
                  end else begin
                     state_ff <= S_CELL_RD;
                  end
               end
            end
            S_CELL_RD: begin
               state_ff <= S_CELL_WB;
            end
            S_CELL_WB: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            S_SWEEP: begin
               if (cnt_ff == SWEEP_END) begin
                  state_ff <= S_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> rtl/core/lge_datapath.sv
// Datapath of the life generation engine: grid banks, row window, rule logic,
// configuration registers and result registers. Depends on lge_pkg.
module lge_datapath
   import lge_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  capture,
   input  lge_cmd_type                           cmd,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]       row_index,
   input  logic [OP_W-1:0]                       req_operation,
   input  logic [COORD_W-1:0]                    req_column,
   input  logic [COORD_W-1:0]                    req_row,
   input  logic                                  req_cell_in,
   input  logic                                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]                  csr_index,
   input  logic [CFG_W-1:0]                      csr_data,
   output logic                                  rsp_valid,
   output logic                                  rsp_cell_value,
   output logic                                  rsp_accepted
);

   localparam int CNT_W = $clog2(MAX_HEIGHT + 1);
   localparam int RA_W  = $clog2(MAX_HEIGHT);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(MAX_HEIGHT);

   // Two banks of row words; bit c of a word is column c.
   logic [MAX_WIDTH-1:0] bank_mem_ff [0:1][0:MAX_HEIGHT-1];

   logic [CFG_W-1:0]     grid_width_ff;
   logic [CFG_W-1:0]     grid_height_ff;
   logic                 active_bank_ff;

   logic [OP_W-1:0]      op_ff;
   logic [COORD_W-1:0]   col_ff;
   logic [COORD_W-1:0]   row_ff;
   logic                 val_ff;

   logic [MAX_WIDTH-1:0] rd_data_ff;
   logic                 sweep_live_ff;
   logic [CNT_W-1:0]     k_ff;
   logic [MAX_WIDTH-1:0] prev2_ff;
   logic [MAX_WIDTH-1:0] prev1_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_cell_ff;
   logic                 rsp_acc_ff;

   logic [CFG_W-1:0]     w_eff;
   logic [CMP_W-1:0]     h_eff;
   logic [CMP_W-1:0]     h_ext;
   logic [CMP_W-1:0]     k_ext;
   logic [MAX_WIDTH-1:0] colmask;
   logic [MAX_WIDTH-1:0] col_sel;
   logic                 in_range;
   logic                 cell_bit;
   logic [MAX_WIDTH-1:0] cell_word;
   logic [MAX_WIDTH-1:0] incoming;
   logic [MAX_WIDTH+1:0] top_pad;
   logic [MAX_WIDTH+1:0] mid_pad;
   logic [MAX_WIDTH+1:0] bot_pad;
   logic [MAX_WIDTH-1:0] rule_row;
   logic [MAX_WIDTH-1:0] gen_row;
   logic                 row_ok;
   logic                 gen_done;

   logic                 mem_we;
   logic                 we_bank;
   logic [RA_W-1:0]      we_addr;
   logic [MAX_WIDTH-1:0] we_data;
   logic                 mem_re;
   logic [RA_W-1:0]      re_addr;

   // Configuration registers, written whenever the port strobes.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_DIM_RESET;
         grid_height_ff <= GRID_DIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective dimensions saturate to 1..MAX.
   always_comb begin
      h_ext = CMP_W'(grid_height_ff);
      if (grid_width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (grid_width_ff > CFG_W'(MAX_WIDTH)) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end else begin
         w_eff = grid_width_ff;
      end
      if (grid_height_ff == '0) begin
         h_eff = CMP_W'(1);
      end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
         h_eff = CMP_W'(MAX_HEIGHT);
      end else begin
         h_eff = h_ext;
      end
   end

   // Column mask and one-hot column select.
   always_comb begin
      for (int c = 0; c < MAX_WIDTH; c++) begin
         colmask[c] = (CFG_W'(c) < w_eff);
         col_sel[c] = (col_ff == COORD_W'(c));
      end
   end

   // Request fields are held for the whole item.
   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff  <= req_operation;
         col_ff <= req_column;
         row_ff <= req_row;
         val_ff <= req_cell_in;
      end
   end

   // Single cell access: bounds check, bit extract and bit update.
   always_comb begin
      in_range  = ({1'b0, col_ff} < w_eff) && (CMP_W'(row_ff) < h_eff);
      cell_bit  = |(rd_data_ff & col_sel);
      cell_word = val_ff ? (rd_data_ff | col_sel) : (rd_data_ff & ~col_sel);
   end

   // Generation: the row arriving from memory is the bottom of the window.
   always_comb begin
      k_ext    = CMP_W'(k_ff);
      incoming = (k_ext < h_eff) ? (rd_data_ff & colmask) : '0;
      row_ok   = (k_ext <= h_eff);
      gen_done = sweep_live_ff && (k_ff == SWEEP_END);
      top_pad  = {1'b0, prev2_ff, 1'b0};
      mid_pad  = {1'b0, prev1_ff, 1'b0};
      bot_pad  = {1'b0, incoming, 1'b0};
   end

   // B3/S23 rule, one independent neighbor count per column.
   always_comb begin
      logic [3:0] sum;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         sum = 4'(top_pad[c]) + 4'(top_pad[c+1]) + 4'(top_pad[c+2])
             + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
             + 4'(bot_pad[c]) + 4'(bot_pad[c+1]) + 4'(bot_pad[c+2]);
         rule_row[c] = (sum == 4'd3) || ((sum == 4'd2) && mid_pad[c+1]);
      end
      gen_row = rule_row & colmask & {MAX_WIDTH{row_ok}};
   end

   // Memory port selection; the sources never overlap in time.
   always_comb begin
      mem_we  = 1'b0;
      we_bank = active_bank_ff;
      we_addr = RA_W'(row_ff);
      we_data = cell_word;
      if (cmd.clear) begin
         mem_we  = 1'b1;
         we_bank = 1'b0;
         we_addr = RA_W'(row_index);
         we_data = '0;
      end else if (cmd.cell_update && (op_ff == OP_WRITE) && in_range) begin
         mem_we = 1'b1;
      end else if (sweep_live_ff && (k_ff != '0)) begin
         mem_we  = 1'b1;
         we_bank = ~active_bank_ff;
         we_addr = RA_W'(k_ff - 1'b1);
         we_data = gen_row;
      end
      mem_re  = cmd.cell_read || (cmd.sweep && (row_index < SWEEP_END));
      re_addr = cmd.sweep ? RA_W'(row_index) : RA_W'(row_ff);
   end

   // Bank memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bank_mem_ff[we_bank][we_addr] <= we_data;
      end
      if (mem_re) begin
         rd_data_ff <= bank_mem_ff[active_bank_ff][re_addr];
      end
   end

   // Sweep tracking and the bank swap at the end of a generation.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_live_ff  <= 1'b0;
         active_bank_ff <= 1'b0;
      end else begin
         sweep_live_ff <= cmd.sweep;
         if (gen_done) begin
            active_bank_ff <= ~active_bank_ff;
         end
      end
   end

   // Row window shift; the top row starts out empty.
   always_ff @(posedge clock) begin
      k_ff <= row_index;
      if (sweep_live_ff) begin
         prev1_ff <= incoming;
         prev2_ff <= (k_ff == '0) ? '0 : prev1_ff;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.cell_update || gen_done;
      end
      if (gen_done) begin
         rsp_cell_ff <= 1'b0;
         rsp_acc_ff  <= 1'b1;
      end else if (cmd.cell_update) begin
         rsp_cell_ff <= (op_ff == OP_READ) && in_range && cell_bit;
         rsp_acc_ff  <= ((op_ff == OP_READ) || (op_ff == OP_WRITE)) && in_range;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_accepted   = rsp_acc_ff;

endmodule

>>> rtl/core/life_generation_engine_top.sv
// Life generation engine, rule B3/S23, on a grid of two row-word banks.
// Cell write or read: row read, then write-back; no new item until the result strobe.
// Generation step: the bank memory reads and writes one row word per cycle, and the result
// follows the last row and the window flush. busy is low again when the result shows.
// Reset (synchronous) clears bank 0 one row at a time with busy high.
// Depends on lge_pkg, lge_control and lge_datapath.
module life_generation_engine_top
   import lge_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [COORD_W-1:0]    req_column,
   input  logic [COORD_W-1:0]    req_row,
   input  logic                  req_cell_in,
   output logic                  rsp_valid,
   output logic                  rsp_cell_value,
   output logic                  rsp_accepted,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int CNT_W = $clog2(MAX_HEIGHT + 1);

   lge_cmd_type       cmd;
   logic              capture;
   logic [CNT_W-1:0]  row_index;

   // Sequencer.
   lge_control #(
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_control (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .busy          (busy),
      .capture       (capture),
      .cmd           (cmd),
      .row_index     (row_index)
   );

   // Grid storage and next-generation logic.
   lge_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .capture          (capture),
      .cmd              (cmd),
      .row_index        (row_index),
      .req_operation    (req_operation),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_cell_in      (req_cell_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_accepted     (rsp_accepted)
   );

endmodule
